// ----- rtl/core/mlrq_pkg.sv -----
// shared codes and types of the multilevel ready queue balancer
package mlrq_pkg;

   // request codes
   localparam logic [1:0] REQ_READY    = 2'd0;
   localparam logic [1:0] REQ_ENQUEUE  = 2'd1;
   localparam logic [1:0] REQ_DEQUEUE  = 2'd2;

   // result status codes
   localparam logic [2:0] ST_LOCAL    = 3'd0;
   localparam logic [2:0] ST_PEER     = 3'd1;
   localparam logic [2:0] ST_DEQUEUED = 3'd2;
   localparam logic [2:0] ST_NONE     = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   // migration modes, the unused code behaves as never
   localparam logic [1:0] MIGRATE_NEVER   = 2'd0;
   localparam logic [1:0] MIGRATE_ALWAYS  = 2'd1;
   localparam logic [1:0] MIGRATE_BALANCE = 2'd2;

   // register file
   localparam int         CSR_ADDR_BITS      = 3;
   localparam logic [0:0] REG_MIGRATE_MODE   = 1'b0;
   localparam logic [0:0] REG_BALANCE_MARGIN = 1'b1;
   localparam logic [1:0] MODE_RESET         = MIGRATE_BALANCE;
   localparam logic [7:0] MARGIN_RESET       = 8'd2;

   typedef enum logic [0:0] {
      ST_IDLE  = 1'b0,
      ST_FETCH = 1'b1
   } ctrl_state_type;

endpackage

// ----- rtl/core/mlrq_req_if.sv -----
// request channel of the ready queue balancer
interface mlrq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] thread_id;
   logic [2:0] priority_req;
   logic       has_affinity;
   logic [3:0] max_level;
   logic [7:0] peer_ready_count;

   modport source (output valid, req_type, thread_id, priority_req, has_affinity, max_level,
                   peer_ready_count, input ready);
   modport sink   (input valid, req_type, thread_id, priority_req, has_affinity, max_level,
                   peer_ready_count, output ready);
endinterface

// ----- rtl/core/mlrq_rsp_if.sv -----
// result channel of the ready queue balancer
interface mlrq_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] out_thread;
   logic [2:0] out_priority;
   logic       wake;
   logic [7:0] ready_count;

   modport source (output valid, status, out_thread, out_priority, wake, ready_count,
                   input ready);
   modport sink   (input valid, status, out_thread, out_priority, wake, ready_count,
                   output ready);
endinterface

// ----- rtl/core/mlrq_ram.sv -----
// generic single-port-write, registered-read memory
module mlrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/multilevel_ready_queue_balancer_unit.sv -----
// top level of the multilevel ready queue balancer
//
//   channel  dir  handshake         payload
//   req_bus  in   valid / ready     req_type thread_id priority_req has_affinity
//                                   max_level peer_ready_count
//   rsp_bus  out  valid / ready     status out_thread out_priority wake ready_count
//   csr_*    in   apb write / read  migrate_mode (0x0), balance_margin (0x4)
//
// every request is decided in the idle state, which also updates the level
// pointers and counts, then the fetch state collects the slot memory read data
// once the output register is free; one request is in flight at a time
// a result waiting in the output register does not block the next request, only
// the load of the following result waits for it
// synchronous active-high reset clears pointers, counts, total, state and valid;
// the slot memory needs no clearing, an entry is read only after it was written
module multilevel_ready_queue_balancer_unit
   import mlrq_pkg::*;
#(
   parameter int NUM_LEVELS     = 8,
   parameter int LEVEL_DEPTH    = 16,
   parameter int THREAD_ID_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   mlrq_req_if.sink                 req_bus,
   mlrq_rsp_if.source               rsp_bus,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int LW   = $clog2(NUM_LEVELS);
   localparam int PW   = $clog2(LEVEL_DEPTH);
   localparam int CW   = $clog2(LEVEL_DEPTH + 1);
   localparam int SLOTS = NUM_LEVELS * LEVEL_DEPTH;
   localparam int AW   = $clog2(SLOTS);
   localparam int TOTW = $clog2(SLOTS + 1);
   localparam int SUMW = (TOTW > 9) ? TOTW : 9;

   // configuration registers
   logic [1:0] mode_ff, mode_in;
   logic [7:0] margin_ff, margin_in;
   logic       csr_wr;

   // per-level queue pointers and fill counts
   logic [PW-1:0]   head_ff  [NUM_LEVELS];
   logic [PW-1:0]   head_in  [NUM_LEVELS];
   logic [PW-1:0]   tail_ff  [NUM_LEVELS];
   logic [PW-1:0]   tail_in  [NUM_LEVELS];
   logic [CW-1:0]   count_ff [NUM_LEVELS];
   logic [CW-1:0]   count_in [NUM_LEVELS];
   logic [TOTW-1:0] total_ff, total_in;

   ctrl_state_type state_ff, state_in;

   // pending result held between accept and fetch
   logic [2:0] pend_status_ff, pend_status_in;
   logic [7:0] pend_thread_ff, pend_thread_in;
   logic [2:0] pend_prio_ff, pend_prio_in;
   logic       pend_wake_ff, pend_wake_in;
   logic [7:0] pend_count_ff, pend_count_in;
   logic       pend_ram_ff, pend_ram_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff;
   logic [7:0] rsp_thread_ff;
   logic [2:0] rsp_prio_ff;
   logic       rsp_wake_ff;
   logic [7:0] rsp_count_ff;

   // request decode
   logic                      req_fire;
   logic                      load_rsp;
   logic [LW-1:0]             push_lvl;
   logic [LW-1:0]             deq_lvl;
   logic                      deq_found;
   logic [NUM_LEVELS-1:0]     full_vec;
   logic [NUM_LEVELS-1:0]     avail_vec;
   logic [SUMW-1:0]           balance_sum;
   logic                      is_push;
   logic                      send_peer;
   logic                      do_push;
   logic                      do_pop;
   logic [TOTW-1:0]           total_sat_src;
   logic [THREAD_ID_BITS-1:0] thr_store;

   // slot memory
   logic [AW-1:0]             wr_addr;
   logic [AW-1:0]             rd_addr;
   logic [THREAD_ID_BITS-1:0] rd_data;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in   = mode_ff;
      margin_in = margin_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_MIGRATE_MODE:   mode_in   = csr_pwdata[1:0];
            REG_BALANCE_MARGIN: margin_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MIGRATE_MODE:   csr_prdata = {30'd0, mode_ff};
         REG_BALANCE_MARGIN: csr_prdata = {24'd0, margin_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- decision
   assign req_fire = req_bus.valid && req_bus.ready;

   // thread level saturates to the last level
   assign push_lvl = (32'(req_bus.priority_req) >= NUM_LEVELS) ?
                     LW'(NUM_LEVELS - 1) : LW'(req_bus.priority_req);

   // full and non-empty flags per level; the dequeue limit is applied here
   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         full_vec[i]  = (32'(count_ff[i]) == LEVEL_DEPTH);
         avail_vec[i] = (count_ff[i] != '0) && (i < 32'(req_bus.max_level));
      end
   end

   // lowest-numbered level with a thread
   always_comb begin
      deq_lvl   = '0;
      deq_found = 1'b0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (avail_vec[i]) begin
            deq_lvl   = LW'(i);
            deq_found = 1'b1;
         end
      end
   end

   assign balance_sum = SUMW'(req_bus.peer_ready_count) + SUMW'(margin_ff);
   assign is_push     = (req_bus.req_type == REQ_READY) || (req_bus.req_type == REQ_ENQUEUE);

   // forwarding only for unpinned ready requests; mode 3 never forwards
   always_comb begin
      send_peer = 1'b0;
      if (req_bus.req_type == REQ_READY && !req_bus.has_affinity) begin
         if (mode_ff == MIGRATE_ALWAYS) begin
            send_peer = 1'b1;
         end else if (mode_ff == MIGRATE_BALANCE) begin
            send_peer = balance_sum < SUMW'(total_ff);
         end
      end
   end

   assign do_push   = req_fire && is_push && !send_peer && !full_vec[push_lvl];
   assign do_pop    = req_fire && (req_bus.req_type == REQ_DEQUEUE) && deq_found;
   assign thr_store = THREAD_ID_BITS'(req_bus.thread_id);

   assign wr_addr = AW'(32'(push_lvl) * LEVEL_DEPTH + 32'(tail_ff[push_lvl]));
   assign rd_addr = AW'(32'(deq_lvl) * LEVEL_DEPTH + 32'(head_ff[deq_lvl]));

   // per-level pointer and count update, at most one level touched
   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         head_in[i]  = head_ff[i];
         tail_in[i]  = tail_ff[i];
         count_in[i] = count_ff[i];
         if (do_push && push_lvl == LW'(i)) begin
            tail_in[i]  = (32'(tail_ff[i]) == LEVEL_DEPTH - 1) ? '0 : tail_ff[i] + 1'b1;
            count_in[i] = count_ff[i] + 1'b1;
         end
         if (do_pop && deq_lvl == LW'(i)) begin
            head_in[i]  = (32'(head_ff[i]) == LEVEL_DEPTH - 1) ? '0 : head_ff[i] + 1'b1;
            count_in[i] = count_ff[i] - 1'b1;
         end
      end
   end

   always_comb begin
      total_in = total_ff;
      if (do_push) begin
         total_in = total_ff + 1'b1;
      end else if (do_pop && total_ff != '0) begin
         total_in = total_ff - 1'b1;
      end
   end

   assign total_sat_src = total_in;

   // pending result fields, thread of a dequeue comes from the slot memory
   always_comb begin
      pend_status_in = pend_status_ff;
      pend_thread_in = pend_thread_ff;
      pend_prio_in   = pend_prio_ff;
      pend_wake_in   = pend_wake_ff;
      pend_count_in  = pend_count_ff;
      pend_ram_in    = pend_ram_ff;
      if (req_fire) begin
         pend_count_in  = (32'(total_sat_src) > 255) ? 8'hFF : 8'(total_sat_src);
         pend_ram_in    = 1'b0;
         pend_wake_in   = 1'b0;
         pend_thread_in = 8'(thr_store);
         pend_prio_in   = 3'(push_lvl);
         if (is_push) begin
            if (send_peer) begin
               pend_status_in = ST_PEER;
            end else if (full_vec[push_lvl]) begin
               pend_status_in = ST_FULL;
            end else begin
               pend_status_in = ST_LOCAL;
               pend_wake_in   = (total_ff == '0);
            end
         end else if (do_pop) begin
            pend_status_in = ST_DEQUEUED;
            pend_ram_in    = 1'b1;
            pend_prio_in   = 3'(deq_lvl);
         end else begin
            pend_status_in = ST_NONE;
            pend_thread_in = 8'd0;
            pend_prio_in   = 3'd0;
         end
      end
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_FETCH;
         ST_FETCH: if (load_rsp) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      load_rsp      = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_bus.ready = 1'b1;
         ST_FETCH: load_rsp      = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         margin_ff    <= MARGIN_RESET;
         total_ff     <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         mode_ff      <= mode_in;
         margin_ff    <= margin_in;
         total_ff     <= total_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_thread_ff <= pend_thread_in;
      pend_prio_ff   <= pend_prio_in;
      pend_wake_ff   <= pend_wake_in;
      pend_count_ff  <= pend_count_in;
      pend_ram_ff    <= pend_ram_in;
      if (load_rsp) begin
         rsp_status_ff <= pend_status_ff;
         rsp_thread_ff <= pend_ram_ff ? 8'(rd_data) : pend_thread_ff;
         rsp_prio_ff   <= pend_prio_ff;
         rsp_wake_ff   <= pend_wake_ff;
         rsp_count_ff  <= pend_count_ff;
      end
   end

   // slot memory: read data holds while the fetch waits on the output register
   mlrq_ram #(
      .WIDTH (THREAD_ID_BITS),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_addr),
      .wr_data (thr_store),
      .rd_en   (do_pop),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.out_thread   = rsp_thread_ff;
   assign rsp_bus.out_priority = rsp_prio_ff;
   assign rsp_bus.wake         = rsp_wake_ff;
   assign rsp_bus.ready_count  = rsp_count_ff;

endmodule

// ----- rtl/core/mlrq_checker.sv -----
// port-level checks of the ready queue balancer and their binding
module mlrq_checker
   import mlrq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] status,
   input logic [7:0] out_thread,
   input logic [2:0] out_priority,
   input logic       wake,
   input logic [7:0] ready_count
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_thread)
                                  && $stable(ready_count))
      else $error("stalled result changed");

   // one request in flight: no transfer right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while one is in flight");

   // wake only when the first thread was queued
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && wake |-> status == ST_LOCAL && ready_count == 8'd1)
      else $error("wake without first local thread");

   // empty search reports no thread and level zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_NONE |-> out_thread == 8'd0 && out_priority == 3'd0 && !wake)
      else $error("none found carries data");

   // a fresh result follows an accepted request, via the fetch state and output register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without request");

endmodule

bind multilevel_ready_queue_balancer_unit mlrq_checker u_mlrq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .status       (rsp_bus.status),
   .out_thread   (rsp_bus.out_thread),
   .out_priority (rsp_bus.out_priority),
   .wake         (rsp_bus.wake),
   .ready_count  (rsp_bus.ready_count)
);

// ----- dv/tb_multilevel_ready_queue_balancer_unit.sv -----
// self-checking testbench of the multilevel ready queue balancer
module tb_multilevel_ready_queue_balancer_unit;
   import mlrq_pkg::*;

   localparam int NUM_LEVELS     = 8;
   localparam int LEVEL_DEPTH    = 16;
   localparam int THREAD_ID_BITS = 8;

   // codes the package leaves unnamed
   localparam logic [1:0] REQ_UNUSED     = 2'd3;
   localparam logic [1:0] MIGRATE_UNUSED = 2'd3;

   // cycles without any transfer before the run is declared hung
   localparam int QUIET_LIMIT    = 3000;
   localparam int RAND_PER_PHASE = 300;
   localparam int RAND_PHASES    = 6;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] thread_id;
      logic [2:0] priority_req;
      logic       has_affinity;
      logic [3:0] max_level;
      logic [7:0] peer_ready_count;
   } sched_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_thread;
      logic [2:0] out_priority;
      logic       wake;
      logic [7:0] ready_count;
   } sched_rsp_type;

   // one line of the directed table: a register write or a run of requests
   typedef struct packed {
      logic          cfg;
      logic [0:0]    reg_sel;
      logic [7:0]    reg_val;
      logic          typed;
      logic [4:0]    reps;
      sched_req_type rq;
      sched_rsp_type want;
   } step_row_type;

   localparam sched_req_type NO_REQ = '0;
   localparam sched_rsp_type NO_RSP = '0;

   // starts from the reset setting: balance mode, margin 2
   localparam step_row_type DIRECTED_STEPS [25] = '{
      // dequeue from an empty queue
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b1, 5'd1,
        '{REQ_DEQUEUE, 8'h00, 3'd0, 1'b0, 4'd8, 8'd0}, '{ST_NONE, 8'h00, 3'd0, 1'b0, 8'd0}},
      // first local thread raises wake
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b1, 5'd1,
        '{REQ_READY, 8'hA5, 3'd3, 1'b0, 4'd0, 8'd0}, '{ST_LOCAL, 8'hA5, 3'd3, 1'b1, 8'd1}},
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b1, 5'd1,
        '{REQ_ENQUEUE, 8'hFF, 3'd7, 1'b1, 4'd15, 8'd255}, '{ST_LOCAL, 8'hFF, 3'd7, 1'b0, 8'd2}},
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b1, 5'd1,
        '{REQ_ENQUEUE, 8'h00, 3'd0, 1'b0, 4'd0, 8'd0}, '{ST_LOCAL, 8'h00, 3'd0, 1'b0, 8'd3}},
      // 0 + 2 below 3: forwarded, local state untouched
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b1, 5'd1,
        '{REQ_READY, 8'h5A, 3'd1, 1'b0, 4'd0, 8'd0}, '{ST_PEER, 8'h5A, 3'd1, 1'b0, 8'd3}},
      // pinned thread stays local
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd1,
        '{REQ_READY, 8'h11, 3'd1, 1'b1, 4'd0, 8'd0}, NO_RSP},
      // peer count plus margin beyond 8 bits must not wrap
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd1,
        '{REQ_READY, 8'h22, 3'd2, 1'b0, 4'd0, 8'd255}, NO_RSP},
      // limit 0 finds nothing
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b1, 5'd1,
        '{REQ_DEQUEUE, 8'h00, 3'd0, 1'b0, 4'd0, 8'd0}, '{ST_NONE, 8'h00, 3'd0, 1'b0, 8'd5}},
      // unused request code changes nothing
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b1, 5'd1,
        '{REQ_UNUSED, 8'hFF, 3'd7, 1'b1, 4'd15, 8'd255}, '{ST_NONE, 8'h00, 3'd0, 1'b0, 8'd5}},
      // limit beyond the levels saturates
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd1,
        '{REQ_DEQUEUE, 8'h00, 3'd0, 1'b0, 4'd15, 8'd0}, NO_RSP},
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd1,
        '{REQ_DEQUEUE, 8'h00, 3'd0, 1'b0, 4'd2, 8'd0}, NO_RSP},
      '{1'b1, REG_MIGRATE_MODE, 8'(MIGRATE_ALWAYS), 1'b0, 5'd0, NO_REQ, NO_RSP},
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b1, 5'd1,
        '{REQ_READY, 8'h33, 3'd4, 1'b0, 4'd0, 8'd128}, '{ST_PEER, 8'h33, 3'd4, 1'b0, 8'd3}},
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd1,
        '{REQ_READY, 8'h44, 3'd4, 1'b1, 4'd0, 8'd0}, NO_RSP},
      '{1'b1, REG_MIGRATE_MODE, 8'(MIGRATE_NEVER), 1'b0, 5'd0, NO_REQ, NO_RSP},
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd1,
        '{REQ_READY, 8'h55, 3'd5, 1'b0, 4'd0, 8'd0}, NO_RSP},
      // unused mode acts as never
      '{1'b1, REG_MIGRATE_MODE, 8'(MIGRATE_UNUSED), 1'b0, 5'd0, NO_REQ, NO_RSP},
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd1,
        '{REQ_READY, 8'h66, 3'd6, 1'b0, 4'd0, 8'd0}, NO_RSP},
      // fill level 6 to the brim, then one more is rejected
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd15,
        '{REQ_ENQUEUE, 8'h70, 3'd6, 1'b0, 4'd0, 8'd0}, NO_RSP},
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd1,
        '{REQ_ENQUEUE, 8'h80, 3'd6, 1'b0, 4'd0, 8'd0}, NO_RSP},
      '{1'b1, REG_MIGRATE_MODE, 8'(MIGRATE_BALANCE), 1'b0, 5'd0, NO_REQ, NO_RSP},
      '{1'b1, REG_BALANCE_MARGIN, 8'd0, 1'b0, 5'd0, NO_REQ, NO_RSP},
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd1,
        '{REQ_DEQUEUE, 8'h00, 3'd0, 1'b0, 4'd8, 8'd0}, NO_RSP},
      // just below and right at the balance threshold
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd1,
        '{REQ_READY, 8'h99, 3'd0, 1'b0, 4'd0, 8'd19}, NO_RSP},
      '{1'b0, REG_MIGRATE_MODE, 8'd0, 1'b0, 5'd1,
        '{REQ_READY, 8'h9A, 3'd0, 1'b0, 4'd0, 8'd20}, NO_RSP}
   };

   // register settings and idling of the random phases
   localparam logic [1:0] PH_MODE      [RAND_PHASES] = '{MIGRATE_BALANCE, MIGRATE_ALWAYS,
      MIGRATE_NEVER, MIGRATE_BALANCE, MIGRATE_UNUSED, MIGRATE_BALANCE};
   localparam logic [7:0] PH_MARGIN    [RAND_PHASES] = '{8'd0, 8'd128, 8'd255, 8'd3, 8'd77,
      8'd1};
   localparam int         PH_SEND_IDLE [RAND_PHASES] = '{12, 12, 72, 72, 0, 0};
   localparam int         PH_RECV_IDLE [RAND_PHASES] = '{72, 72, 12, 12, 0, 0};

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0]              csr_pwdata;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   mlrq_req_if req_if ();
   mlrq_rsp_if rsp_if ();

   multilevel_ready_queue_balancer_unit #(
      .NUM_LEVELS     (NUM_LEVELS),
      .LEVEL_DEPTH    (LEVEL_DEPTH),
      .THREAD_ID_BITS (THREAD_ID_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // shadow of the ready queues: per-level ring of thread ids
   logic [7:0] lvl_slots [NUM_LEVELS][LEVEL_DEPTH];
   int         lvl_rd    [NUM_LEVELS];
   int         lvl_wr    [NUM_LEVELS];
   int         lvl_fill  [NUM_LEVELS];
   int         local_total;
   logic [1:0] cur_mode;
   logic [7:0] cur_margin;

   // scheduler answers still to come back, oldest first
   sched_rsp_type outcomes_due [$];

   int fail_count   = 0;
   int quiet_cycles = 0;
   int send_idle;
   int recv_idle;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%s", msg);
   endfunction

   // applies one request to the shadow queues and returns the scheduler's answer
   function automatic sched_rsp_type resolve_request(input sched_req_type rq);
      sched_rsp_type ans;
      int            lvl;
      int            lim;
      int            i;
      logic          fwd;
      logic          found;
      ans   = '0;
      lvl   = int'(rq.priority_req);
      lim   = (rq.max_level > NUM_LEVELS) ? NUM_LEVELS : int'(rq.max_level);
      fwd   = 1'b0;
      found = 1'b0;
      case (rq.req_type)
         REQ_READY, REQ_ENQUEUE: begin
            // only an unpinned ready request may go to the peer
            if (rq.req_type == REQ_READY && !rq.has_affinity) begin
               if (cur_mode == MIGRATE_ALWAYS)
                  fwd = 1'b1;
               else if (cur_mode == MIGRATE_BALANCE)
                  fwd = (int'(rq.peer_ready_count) + int'(cur_margin)) < local_total;
            end
            ans.out_thread   = rq.thread_id;
            ans.out_priority = rq.priority_req;
            if (fwd) begin
               ans.status = ST_PEER;
            end else if (lvl_fill[lvl] >= LEVEL_DEPTH) begin
               ans.status = ST_FULL;
            end else begin
               lvl_slots[lvl][lvl_wr[lvl]] = rq.thread_id;
               lvl_wr[lvl]   = (lvl_wr[lvl] + 1) % LEVEL_DEPTH;
               lvl_fill[lvl] = lvl_fill[lvl] + 1;
               local_total   = local_total + 1;
               ans.status    = ST_LOCAL;
               ans.wake      = (local_total == 1);
            end
         end
         REQ_DEQUEUE: begin
            ans.status = ST_NONE;
            for (i = 0; i < lim && !found; i++) begin
               if (lvl_fill[i] != 0) begin
                  found            = 1'b1;
                  ans.status       = ST_DEQUEUED;
                  ans.out_thread   = lvl_slots[i][lvl_rd[i]];
                  ans.out_priority = 3'(i);
                  lvl_rd[i]        = (lvl_rd[i] + 1) % LEVEL_DEPTH;
                  lvl_fill[i]      = lvl_fill[i] - 1;
                  if (local_total != 0)
                     local_total = local_total - 1;
               end
            end
         end
         default: begin
            ans.status = ST_NONE;
         end
      endcase
      ans.ready_count = (local_total > 255) ? 8'd255 : 8'(local_total);
      return ans;
   endfunction

   // one request transfer, after a random gap; valid stays high for the next one
   task automatic send_request(input sched_req_type rq, input logic typed,
                               input sched_rsp_type want);
      sched_rsp_type calc;
      while ($urandom_range(0, 99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid            <= 1'b1;
      req_if.req_type         <= rq.req_type;
      req_if.thread_id        <= rq.thread_id;
      req_if.priority_req     <= rq.priority_req;
      req_if.has_affinity     <= rq.has_affinity;
      req_if.max_level        <= rq.max_level;
      req_if.peer_ready_count <= rq.peer_ready_count;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      // the shadow state moves even where the answer is typed into the table
      calc = resolve_request(rq);
      outcomes_due = {outcomes_due, typed ? want : calc};
   endtask

   // hold off new requests until every answer is back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (outcomes_due.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [0:0] sel, input logic [7:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= 32'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      // register takes the value at this edge
      if (sel == REG_MIGRATE_MODE)
         cur_mode = val[1:0];
      else
         cur_margin = val;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [0:0] sel);
      logic [31:0] want;
      want        = (sel == REG_MIGRATE_MODE) ? 32'(cur_mode) : 32'(cur_margin);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {sel, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata !== want)
         note_failure($sformatf("register %0d read: want %0h, got %0h", sel, want,
                                csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // result side stalls at random
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // every result transfer is held against the oldest open answer
   always @(posedge clock) begin : rsp_compare
      sched_rsp_type due;
      sched_rsp_type seen;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen = '{rsp_if.status, rsp_if.out_thread, rsp_if.out_priority, rsp_if.wake,
                  rsp_if.ready_count};
         if (outcomes_due.size() == 0) begin
            note_failure($sformatf("result transfer with nothing open: st=%0d thr=%0h",
                                   seen.status, seen.out_thread));
         end else begin
            due = outcomes_due[0];
            outcomes_due.delete(0);
            if (seen.status !== due.status || seen.out_thread !== due.out_thread ||
                seen.out_priority !== due.out_priority || seen.wake !== due.wake ||
                seen.ready_count !== due.ready_count)
               note_failure($sformatf(
                  {"result mismatch: want st=%0d thr=%0h lvl=%0d wake=%0b cnt=%0d, ",
                   "got st=%0d thr=%0h lvl=%0d wake=%0b cnt=%0d"},
                  due.status, due.out_thread, due.out_priority, due.wake, due.ready_count,
                  seen.status, seen.out_thread, seen.out_priority, seen.wake,
                  seen.ready_count));
         end
      end
   end

   // hang detection: any transfer or register access restarts the count
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      sched_req_type rq;
      int            r;
      int            k;
      int            ph;
      int            n;
      int            roll;
      int            push_pct;
      int            hot;

      // every input known from time zero
      reset                   = 1'b1;
      req_if.valid            = 1'b0;
      req_if.req_type         = REQ_READY;
      req_if.thread_id        = '0;
      req_if.priority_req     = '0;
      req_if.has_affinity     = 1'b0;
      req_if.max_level        = '0;
      req_if.peer_ready_count = '0;
      rsp_if.ready            = 1'b0;
      csr_psel                = 1'b0;
      csr_penable             = 1'b0;
      csr_pwrite              = 1'b0;
      csr_paddr               = '0;
      csr_pwdata              = '0;
      send_idle               = 12;
      recv_idle               = 72;
      push_pct                = 50;
      hot                     = 0;

      // shadow state after reset
      for (r = 0; r < NUM_LEVELS; r++) begin
         lvl_rd[r]   = 0;
         lvl_wr[r]   = 0;
         lvl_fill[r] = 0;
      end
      local_total = 0;
      cur_mode    = MODE_RESET;
      cur_margin  = MARGIN_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the registers
      csr_check(REG_MIGRATE_MODE);
      csr_check(REG_BALANCE_MARGIN);

      // directed table
      for (r = 0; r < $size(DIRECTED_STEPS); r++) begin
         if (DIRECTED_STEPS[r].cfg) begin
            wait_drained();
            csr_write(DIRECTED_STEPS[r].reg_sel, DIRECTED_STEPS[r].reg_val);
            csr_check(DIRECTED_STEPS[r].reg_sel);
         end else begin
            for (k = 0; k < int'(DIRECTED_STEPS[r].reps); k++) begin
               rq           = DIRECTED_STEPS[r].rq;
               rq.thread_id = rq.thread_id + 8'(k);
               send_request(rq, DIRECTED_STEPS[r].typed, DIRECTED_STEPS[r].want);
            end
         end
      end

      // random phases, each under its own register setting and idling
      for (ph = 0; ph < RAND_PHASES; ph++) begin
         wait_drained();
         csr_write(REG_MIGRATE_MODE, 8'(PH_MODE[ph]));
         csr_write(REG_BALANCE_MARGIN, PH_MARGIN[ph]);
         csr_check(REG_MIGRATE_MODE);
         csr_check(REG_BALANCE_MARGIN);
         send_idle = PH_SEND_IDLE[ph];
         recv_idle = PH_RECV_IDLE[ph];
         for (n = 0; n < RAND_PER_PHASE; n++) begin
            // bursts that fill or drain, aimed at one hot level, so levels run full
            // and the queue empties again
            if (n % 40 == 0) begin
               case ($urandom_range(0, 2))
                  0:       push_pct = 85;
                  1:       push_pct = 50;
                  default: push_pct = 20;
               endcase
               hot = $urandom_range(0, NUM_LEVELS - 1);
            end
            // sender stops until the queue of answers is empty
            if (ph == 0 && n == RAND_PER_PHASE / 2)
               wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 3)
               rq.req_type = REQ_UNUSED;
            else if (roll < push_pct)
               rq.req_type = $urandom_range(0, 1) ? REQ_READY : REQ_ENQUEUE;
            else
               rq.req_type = REQ_DEQUEUE;
            rq.thread_id    = 8'($urandom_range(0, 255));
            rq.priority_req = $urandom_range(0, 1) ? 3'(hot) : 3'($urandom_range(0, 7));
            rq.has_affinity = ($urandom_range(0, 99) < 30);
            rq.max_level    = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'($urandom_range(1, 8));
            // peer counts mostly near the local total to work the balance compare
            rq.peer_ready_count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                  : 8'($urandom_range(0, local_total + 4));
            send_request(rq, 1'b0, NO_RSP);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
